>>> hdl/thermadc_pkg.sv
// Shared constants, segment table and divider handshake types for the thermistor converter.
`timescale 1ns / 1ps
`default_nettype none
package thermadc_pkg;

  localparam int unsigned SPR         = 10;   // samples per result
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned CNT_W       = $clog2(SPR);
  localparam int unsigned SUM_W       = SAMPLE_BITS + $clog2(SPR);
  localparam int unsigned CFG_W       = 16;
  localparam int unsigned PROD_W      = SAMPLE_BITS + CFG_W;
  localparam int unsigned DIV_W       = PROD_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_W);
  localparam int unsigned MUL_CNT_W   = $clog2(SAMPLE_BITS);
  localparam int unsigned RES_W       = 18;
  localparam int unsigned TEMP_W      = 9;
  localparam int unsigned SLOPE_W     = 14;
  localparam int unsigned SEG_N       = 17;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 32;
  localparam int unsigned REG_IDX_W   = 2;

  localparam logic [RES_W-1:0] RES_MAX = {RES_W{1'b1}};

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_SCALE = REG_IDX_W'(0);
  localparam logic [REG_IDX_W-1:0] REG_REF   = REG_IDX_W'(1);

  localparam logic [CFG_W-1:0] SCALE_RST = 16'd10000;
  localparam logic [CFG_W-1:0] REF_RST   = 16'd3300;

  typedef struct packed {
    logic [RES_W-1:0]          lo;     // inclusive
    logic [RES_W-1:0]          hi;     // exclusive
    logic [RES_W-1:0]          icept;
    logic [SLOPE_W-1:0]        slope;
    logic signed [TEMP_W-1:0]  base;
  } seg_t;

  // Tried in order; first hit wins.
  localparam seg_t SEG_TABLE [SEG_N] = '{
    '{18'd18680,  18'd29371,  18'd29370,  14'd1069,  9'sd0},
    '{18'd12240,  18'd18681,  18'd18680,  14'd644,   9'sd10},
    '{18'd8221,   18'd12241,  18'd11500,  14'd402,   9'sd20},
    '{18'd5648,   18'd8222,   18'd9500,   14'd257,   9'sd30},
    '{18'd3958,   18'd5649,   18'd5648,   14'd169,   9'sd40},
    '{18'd2823,   18'd3959,   18'd3850,   14'd114,   9'sd50},
    '{18'd2047,   18'd2824,   18'd2956,   14'd78,    9'sd60},
    '{18'd1506,   18'd2048,   18'd2048,   14'd54,    9'sd70},
    '{18'd1124,   18'd1507,   18'd1507,   14'd38,    9'sd80},
    '{18'd850,    18'd1125,   18'd1125,   14'd27,    9'sd90},
    '{18'd651,    18'd851,    18'd851,    14'd20,    9'sd100},
    '{18'd504,    18'd652,    18'd652,    14'd15,    9'sd110},
    '{18'd395,    18'd505,    18'd505,    14'd11,    9'sd120},
    '{18'd29370,  18'd47731,  18'd47730,  14'd1836,  -9'sd10},
    '{18'd47730,  18'd80361,  18'd80360,  14'd3263,  -9'sd20},
    '{18'd80360,  18'd140001, 18'd140000, 14'd5964,  -9'sd30},
    '{18'd140000, 18'd249600, 18'd249600, 14'd10960, -9'sd40}
  };

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [CFG_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

>>> hdl/thermadc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module thermadc_div (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  thermadc_pkg::div_req_t req_i,
  output thermadc_pkg::div_rsp_t rsp_o
);

  logic                                busy_q, busy_d;
  logic                                done_q, done_d;
  logic [thermadc_pkg::DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [thermadc_pkg::CFG_W-1:0]      rem_q, rem_d;
  logic [thermadc_pkg::DIV_W-1:0]      quo_q, quo_d;
  logic [thermadc_pkg::CFG_W-1:0]      dvs_q, dvs_d;

  logic [thermadc_pkg::CFG_W:0] trial;
  logic [thermadc_pkg::CFG_W:0] diff;
  logic                         fits;

  assign trial = {rem_q, quo_q[thermadc_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = thermadc_pkg::DIV_CNT_W'(thermadc_pkg::DIV_W - 1);
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the low bits hold it
      rem_d = fits ? diff[thermadc_pkg::CFG_W-1:0] : trial[thermadc_pkg::CFG_W-1:0];
      quo_d = {quo_q[thermadc_pkg::DIV_W-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && cnt_q == '0 && !req_i.start) |=> (done_q && !busy_q))
    else $error("divider missed its done pulse");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q)
    else $error("divider done held longer than one cycle");
`endif

endmodule
`default_nettype wire

>>> hdl/thermistor_adc_to_temperature.sv
// Top level: sample averager, divider resistance and piecewise-linear temperature lookup.
// Usage:
//   s_axis_*  : one 10-bit converter sample per transfer. Samples are taken
//               while the block accumulates; every tenth sample starts a conversion.
//   m_axis_*  : one result per ten samples: temperature and 3x resistance in tdata,
//               in-range flag in tuser.
//   cfg_*     : register writes (0 divider scale, 1 divider reference), always ready;
//               other indexes are ignored. Write only while the block is idle.
// Conversion: from the tenth sample to m_axis_tvalid the work runs through one shared
//   bit-serial divider in three passes (mean, resistance, segment quotient) and a
//   shift-add multiplier; the resistance pass is skipped when the reference is not
//   above the mean, the segment pass when no segment holds the resistance. During
//   that time s_axis_tready is low: no new batch is taken until the result is stored.
// If the reference is not above the mean, resistance reads saturated and the
//   result is out of range (temperature 0, tuser 0).
// Stall: results sit in an output register; samples keep being accumulated while
//   it waits. A finished conversion waits only if the previous result is still
//   untaken, and holds s_axis_tready low until the register frees.
// Reset: registers take their defaults (scale 10000, reference 3300), the
//   accumulator and sample count clear, no result is pending.
`timescale 1ns / 1ps
`default_nettype none
module thermistor_adc_to_temperature (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  // tdata: [9:0] adc_sample
  input  wire  [thermadc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  wire                                      s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tdata: [8:0] temperature, [26:9] resistance
  output logic [thermadc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // tuser: [0] in_range
  output logic [0:0]                               m_axis_tuser,
  output logic                                     m_axis_tvalid,
  input  wire                                      m_axis_tready,
  input  wire                                      cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire  [thermadc_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  wire  [thermadc_pkg::CFG_W-1:0]           cfg_data_i
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_MEAN = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_DIV  = 7'b0001000,
    S_SEG  = 7'b0010000,
    S_TEMP = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  logic [thermadc_pkg::SUM_W-1:0]        sum_q, sum_d;
  logic [thermadc_pkg::CNT_W-1:0]        cnt_q, cnt_d;
  logic [thermadc_pkg::CFG_W-1:0]        scale_q, scale_d;
  logic [thermadc_pkg::CFG_W-1:0]        ref_q, ref_d;
  logic                                  m_valid_q, m_valid_d;
  logic                                  start_q, start_d;

  // datapath registers, no reset (but for mul_cnt_q)
  logic [thermadc_pkg::DIV_W-1:0]        dvd_q, dvd_d;
  logic [thermadc_pkg::CFG_W-1:0]        dvs_q, dvs_d;
  logic [thermadc_pkg::SAMPLE_BITS-1:0]  mean_q, mean_d;
  logic [thermadc_pkg::PROD_W-1:0]       mcand_q, mcand_d;
  logic [thermadc_pkg::SAMPLE_BITS-1:0]  mplier_q, mplier_d;
  logic [thermadc_pkg::PROD_W-1:0]       acc_q, acc_d;
  logic [thermadc_pkg::MUL_CNT_W-1:0]    mul_cnt_q, mul_cnt_d;
  logic [thermadc_pkg::RES_W-1:0]        res3_q, res3_d;
  logic signed [thermadc_pkg::TEMP_W-1:0] base_q, base_d;
  logic                                  neg_q, neg_d;
  logic signed [thermadc_pkg::TEMP_W-1:0] temp_q, temp_d;
  logic                                  ok_q, ok_d;
  logic signed [thermadc_pkg::TEMP_W-1:0] o_temp_q, o_temp_d;
  logic                                  o_ok_q, o_ok_d;
  logic [thermadc_pkg::RES_W-1:0]        o_res_q, o_res_d;

  thermadc_pkg::div_req_t div_req;
  thermadc_pkg::div_rsp_t div_rsp;

  logic                                  in_xfer;
  logic [thermadc_pkg::SUM_W-1:0]        sum_new;
  logic [thermadc_pkg::CFG_W-1:0]        mean_ext;
  logic [thermadc_pkg::PROD_W-1:0]       acc_next;
  logic [thermadc_pkg::PROD_W+1:0]       r3_full;
  logic                                  seg_hit;
  thermadc_pkg::seg_t                    seg_sel;
  logic                                  seg_neg;
  logic [thermadc_pkg::RES_W-1:0]        seg_num;
  logic signed [thermadc_pkg::TEMP_W-1:0] quo_s;
  logic signed [thermadc_pkg::TEMP_W-1:0] temp_sum;

  assign s_axis_tready = (state_q == S_IDLE);
  assign cfg_ready_o   = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  assign sum_new  = sum_q + {{(thermadc_pkg::SUM_W - thermadc_pkg::SAMPLE_BITS){1'b0}},
                             s_axis_tdata[thermadc_pkg::SAMPLE_BITS-1:0]};
  assign mean_ext = {{(thermadc_pkg::CFG_W - thermadc_pkg::SAMPLE_BITS){1'b0}}, mean_q};
  // shift-add multiply, multiplier LSB first
  assign acc_next = acc_q + (mplier_q[0] ? mcand_q : '0);
  // 3R = R + 2R
  assign r3_full  = {2'b00, div_rsp.quotient} + {1'b0, div_rsp.quotient, 1'b0};
  // quotient of the magnitude; the sign of the numerator picks add or subtract,
  // which keeps truncation toward zero
  assign quo_s    = $signed(div_rsp.quotient[thermadc_pkg::TEMP_W-1:0]);
  assign temp_sum = neg_q ? (base_q - quo_s) : (base_q + quo_s);

  // Segment search: all compares in parallel, lowest index wins.
  always_comb begin
    seg_hit = 1'b0;
    seg_sel = thermadc_pkg::SEG_TABLE[0];
    for (int i = thermadc_pkg::SEG_N - 1; i >= 0; i--) begin
      if (res3_q >= thermadc_pkg::SEG_TABLE[i].lo && res3_q < thermadc_pkg::SEG_TABLE[i].hi) begin
        seg_hit = 1'b1;
        seg_sel = thermadc_pkg::SEG_TABLE[i];
      end
    end
  end
  // some intercepts sit inside their segment, so the numerator can go negative
  assign seg_neg = (res3_q > seg_sel.icept);
  assign seg_num = seg_neg ? (res3_q - seg_sel.icept) : (seg_sel.icept - res3_q);

  always_comb begin
    state_d   = state_q;
    sum_d     = sum_q;
    cnt_d     = cnt_q;
    scale_d   = scale_q;
    ref_d     = ref_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    start_d   = 1'b0;
    dvd_d     = dvd_q;
    dvs_d     = dvs_q;
    mean_d    = mean_q;
    mcand_d   = mcand_q;
    mplier_d  = mplier_q;
    acc_d     = acc_q;
    mul_cnt_d = mul_cnt_q;
    res3_d    = res3_q;
    base_d    = base_q;
    neg_d     = neg_q;
    temp_d    = temp_q;
    ok_d      = ok_q;
    o_temp_d  = o_temp_q;
    o_ok_d    = o_ok_q;
    o_res_d   = o_res_q;

    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        thermadc_pkg::REG_SCALE: scale_d = cfg_data_i;
        thermadc_pkg::REG_REF:   ref_d   = cfg_data_i;
        default: ;
      endcase
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (cnt_q == thermadc_pkg::CNT_W'(thermadc_pkg::SPR - 1)) begin
            sum_d   = '0;
            cnt_d   = '0;
            dvd_d   = {{(thermadc_pkg::DIV_W - thermadc_pkg::SUM_W){1'b0}}, sum_new};
            dvs_d   = thermadc_pkg::CFG_W'(thermadc_pkg::SPR);
            start_d = 1'b1;
            state_d = S_MEAN;
          end else begin
            sum_d = sum_new;
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      S_MEAN: begin
        if (div_rsp.done) begin
          mean_d    = div_rsp.quotient[thermadc_pkg::SAMPLE_BITS-1:0];
          mplier_d  = div_rsp.quotient[thermadc_pkg::SAMPLE_BITS-1:0];
          mcand_d   = {{(thermadc_pkg::PROD_W - thermadc_pkg::CFG_W){1'b0}}, scale_q};
          acc_d     = '0;
          mul_cnt_d = thermadc_pkg::MUL_CNT_W'(thermadc_pkg::SAMPLE_BITS - 1);
          state_d   = S_MUL;
        end
      end
      S_MUL: begin
        acc_d    = acc_next;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        if (mul_cnt_q == '0) begin
          if (ref_q <= mean_ext) begin
            // divisor zero or negative: saturate
            res3_d  = thermadc_pkg::RES_MAX;
            state_d = S_SEG;
          end else begin
            dvd_d   = acc_next;
            dvs_d   = ref_q - mean_ext;
            start_d = 1'b1;
            state_d = S_DIV;
          end
        end else begin
          mul_cnt_d = mul_cnt_q - 1'b1;
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          res3_d  = (r3_full > {{(thermadc_pkg::PROD_W + 2 - thermadc_pkg::RES_W){1'b0}},
                                thermadc_pkg::RES_MAX})
                    ? thermadc_pkg::RES_MAX : r3_full[thermadc_pkg::RES_W-1:0];
          state_d = S_SEG;
        end
      end
      S_SEG: begin
        if (seg_hit) begin
          dvd_d   = {{(thermadc_pkg::DIV_W - thermadc_pkg::RES_W){1'b0}}, seg_num};
          dvs_d   = {{(thermadc_pkg::CFG_W - thermadc_pkg::SLOPE_W){1'b0}}, seg_sel.slope};
          base_d  = seg_sel.base;
          neg_d   = seg_neg;
          start_d = 1'b1;
          state_d = S_TEMP;
        end else begin
          temp_d  = '0;
          ok_d    = 1'b0;
          state_d = S_OUT;
        end
      end
      S_TEMP: begin
        if (div_rsp.done) begin
          temp_d  = temp_sum;
          ok_d    = 1'b1;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          o_temp_d  = temp_q;
          o_ok_d    = ok_q;
          o_res_d   = res3_q;
          m_valid_d = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      sum_q     <= '0;
      cnt_q     <= '0;
      scale_q   <= thermadc_pkg::SCALE_RST;
      ref_q     <= thermadc_pkg::REF_RST;
      m_valid_q <= 1'b0;
      start_q   <= 1'b0;
      mul_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      scale_q   <= scale_d;
      ref_q     <= ref_d;
      m_valid_q <= m_valid_d;
      start_q   <= start_d;
      mul_cnt_q <= mul_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q    <= dvd_d;
    dvs_q    <= dvs_d;
    mean_q   <= mean_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    res3_q   <= res3_d;
    base_q   <= base_d;
    neg_q    <= neg_d;
    temp_q   <= temp_d;
    ok_q     <= ok_d;
    o_temp_q <= o_temp_d;
    o_ok_q   <= o_ok_d;
    o_res_q  <= o_res_d;
  end

  assign div_req.start    = start_q;
  assign div_req.dividend = dvd_q;
  assign div_req.divisor  = dvs_q;

  thermadc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(thermadc_pkg::OUT_TDATA_W - thermadc_pkg::RES_W
                            - thermadc_pkg::TEMP_W){1'b0}}, o_res_q, o_temp_q};
  assign m_axis_tuser  = o_ok_q;

`ifndef SYNTHESIS
  a_busy_after_batch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && cnt_q == thermadc_pkg::CNT_W'(thermadc_pkg::SPR - 1)) |=> !s_axis_tready)
    else $error("sample taken during conversion");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= thermadc_pkg::CNT_W'(thermadc_pkg::SPR - 1))
    else $error("sample count overran the batch");

  a_out_zero_temp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !o_ok_q) |-> (o_temp_q == '0))
    else $error("out-of-range result with nonzero temperature");

  a_sat_out_of_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && o_res_q == thermadc_pkg::RES_MAX) |-> !o_ok_q)
    else $error("saturated resistance flagged in range");
`endif

endmodule
`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the thermistor sample averager and temperature converter.
`timescale 1ns / 1ps
module tb_top;
  localparam int IN_TDATA_W  = thermadc_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = thermadc_pkg::OUT_TDATA_W;
  localparam int REG_IDX_W   = thermadc_pkg::REG_IDX_W;
  localparam int CFG_W       = thermadc_pkg::CFG_W;
  localparam logic [REG_IDX_W-1:0] REG_SCALE = thermadc_pkg::REG_SCALE;
  localparam logic [REG_IDX_W-1:0] REG_REF   = thermadc_pkg::REG_REF;

  localparam int ADC_BITS      = 10;
  localparam int BATCH_LEN     = 10;       // samples averaged per reading
  localparam int SEG_COUNT     = 17;
  localparam longint unsigned RES3_SAT = 262143;
  localparam int SETTLE_CYCLES = 150;
  localparam int QUIET_LIMIT   = 3000;     // cycles without any transfer
  localparam int RANDOM_PHASES = 16;

  // Indexes that the block must ignore
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  localparam logic [CFG_W-1:0] SCALE_DEFAULT = 16'd10000;
  localparam logic [CFG_W-1:0] REF_DEFAULT   = 16'd3300;

  typedef struct packed {
    logic [8:0]  temperature;
    logic        in_range;
    logic [17:0] resistance;
  } reading_t;

  // Resistance segments (bounds on 3R), tried in order
  int seg_lo    [SEG_COUNT] = '{18680, 12240, 8221, 5648, 3958, 2823, 2047, 1506, 1124,
                                850, 651, 504, 395, 29370, 47730, 80360, 140000};
  int seg_hi    [SEG_COUNT] = '{29371, 18681, 12241, 8222, 5649, 3959, 2824, 2048, 1507,
                                1125, 851, 652, 505, 47731, 80361, 140001, 249600};
  int seg_icept [SEG_COUNT] = '{29370, 18680, 11500, 9500, 5648, 3850, 2956, 2048, 1507,
                                1125, 851, 652, 505, 47730, 80360, 140000, 249600};
  int seg_slope [SEG_COUNT] = '{1069, 644, 402, 257, 169, 114, 78, 54, 38,
                                27, 20, 15, 11, 1836, 3263, 5964, 10960};
  int seg_base  [SEG_COUNT] = '{0, 10, 20, 30, 40, 50, 60, 70, 80,
                                90, 100, 110, 120, -10, -20, -30, -40};

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   s_axis_tvalid = 1'b0;
  wire                    s_axis_tready;
  wire [OUT_TDATA_W-1:0]  m_axis_tdata;
  wire [0:0]              m_axis_tuser;
  wire                    m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic                   cfg_valid_i   = 1'b0;
  wire                    cfg_ready_o;
  logic [REG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_W-1:0]       cfg_data_i    = '0;

  thermistor_adc_to_temperature dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor state: register shadows and the running batch
  logic [CFG_W-1:0] scale_reg     = SCALE_DEFAULT;
  logic [CFG_W-1:0] reference_reg = REF_DEFAULT;
  int unsigned      batch_sum     = 0;
  int unsigned      batch_count   = 0;

  logic [ADC_BITS-1:0] sample_feed_q[$];
  reading_t            temp_readings_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit sample_taken   = 1'b0;

  int mismatch_count    = 0;
  int samples_in        = 0;
  int readings_checked  = 0;
  int out_of_range_seen = 0;
  int saturated_seen    = 0;
  int quiet_cycles      = 0;
  logic [SEG_COUNT-1:0] seg_seen = '0;

  // Mean -> 3x divider resistance -> segment lookup
  function automatic reading_t convert_mean(input int unsigned mean);
    reading_t         rd;
    longint unsigned  num;
    longint unsigned  den;
    longint unsigned  ohms3;
    int               r3;
    rd = '0;
    if (reference_reg <= mean) begin
      ohms3 = RES3_SAT;
    end else begin
      num   = mean;
      num   = num * scale_reg;
      den   = reference_reg - mean;
      ohms3 = (num / den) * 3;
      if (ohms3 > RES3_SAT) ohms3 = RES3_SAT;
    end
    rd.resistance = ohms3[17:0];
    r3 = int'(ohms3);
    for (int i = 0; i < SEG_COUNT; i++) begin
      if (!rd.in_range && r3 >= seg_lo[i] && r3 < seg_hi[i]) begin
        // int division truncates toward zero, as the segment formula requires
        rd.temperature = 9'((seg_icept[i] - r3) / seg_slope[i] + seg_base[i]);
        rd.in_range    = 1'b1;
        seg_seen[i]    = 1'b1;
      end
    end
    return rd;
  endfunction

  task automatic absorb_sample(input logic [ADC_BITS-1:0] sample);
    batch_sum   += sample;
    batch_count += 1;
    samples_in  += 1;
    if (batch_count == BATCH_LEN) begin
      temp_readings_q.push_back(convert_mean(batch_sum / BATCH_LEN));
      batch_sum   = 0;
      batch_count = 0;
    end
  endtask

  task automatic report_field(input string name, input longint want, input longint got);
    $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    mismatch_count += 1;
  endtask

  // Driver: inputs change on the falling edge
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || sample_taken) begin
      sample_taken = 1'b0;
      if (rst_ni && sample_feed_q.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata  <= IN_TDATA_W'(sample_feed_q.pop_front());
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= rst_ni && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Monitor: transfers sampled on the rising edge; also runs the watchdog
  always @(posedge clk_i) begin
    reading_t want;
    if (rst_ni) begin
      quiet_cycles += 1;
      if (s_axis_tvalid && s_axis_tready) begin
        sample_taken = 1'b1;
        absorb_sample(s_axis_tdata[ADC_BITS-1:0]);
        quiet_cycles = 0;
      end
      if (cfg_valid_i && cfg_ready_o) quiet_cycles = 0;
      if (m_axis_tvalid && m_axis_tready) begin
        quiet_cycles = 0;
        if (temp_readings_q.size() == 0) begin
          $display("%0t ns: unexpected reading, expected none, actual tdata %h tuser %b",
                   $time, m_axis_tdata, m_axis_tuser);
          mismatch_count += 1;
        end else begin
          want = temp_readings_q.pop_front();
          readings_checked += 1;
          if (!want.in_range) out_of_range_seen += 1;
          if (want.resistance == RES3_SAT[17:0]) saturated_seen += 1;
          if (m_axis_tdata[8:0] != want.temperature)
            report_field("temperature", $signed(want.temperature),
                         $signed(m_axis_tdata[8:0]));
          if (m_axis_tdata[26:9] != want.resistance)
            report_field("resistance", want.resistance, m_axis_tdata[26:9]);
          if (m_axis_tuser[0] != want.in_range)
            report_field("in_range", want.in_range, m_axis_tuser[0]);
          if (m_axis_tdata[OUT_TDATA_W-1:27] != '0)
            report_field("tdata padding", 0, m_axis_tdata[OUT_TDATA_W-1:27]);
        end
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles, %0d readings outstanding",
                 $time, QUIET_LIMIT, temp_readings_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == REG_SCALE)
      scale_reg = val;
    else if (idx == REG_REF)
      reference_reg = val;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // One batch: mostly a steady level with a little noise, sometimes pure noise
  task automatic queue_batch();
    int level;
    int v;
    bit raw;
    raw = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0: level = $urandom_range(960, 1023);
      1: level = $urandom_range(0, 40);
      default: level = $urandom_range(0, 1023);
    endcase
    for (int i = 0; i < BATCH_LEN; i++) begin
      if (raw) begin
        v = $urandom_range(0, 1023);
      end else begin
        v = level + int'($urandom_range(0, 12)) - 6;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
      end
      sample_feed_q.push_back(ADC_BITS'(v));
    end
  endtask

  // Sender holds off until the block has delivered everything, then lets it settle
  task automatic drain_and_settle();
    while (sample_feed_q.size() != 0 || s_axis_tvalid || temp_readings_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [CFG_W-1:0] ref_pick;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset defaults, no idling: all-zero batch (R = 0) and all-ones batch
    repeat (BATCH_LEN) sample_feed_q.push_back(10'h000);
    repeat (BATCH_LEN) sample_feed_q.push_back(10'h3ff);
    repeat (5) queue_batch();
    drain_and_settle();

    for (int p = 1; p <= RANDOM_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      case (p % 8)
        1: begin  // zero scale: R = 0, never in a segment
          write_reg(REG_SCALE, 16'd0);
          write_reg(REG_REF, REF_DEFAULT);
        end
        2: begin  // low reference: saturated, out of range where not above mean
          write_reg(REG_SCALE, SCALE_DEFAULT);
          write_reg(REG_REF, (p < 8) ? 16'd0 : CFG_W'($urandom_range(1, 1023)));
        end
        3: begin  // divisor tiny for high means: resistance saturates
          write_reg(REG_SCALE, 16'hffff);
          write_reg(REG_REF, 16'd1024);
        end
        4: begin
          write_reg(REG_SCALE, 16'hffff);
          write_reg(REG_REF, 16'hffff);
        end
        5: begin
          write_reg(REG_SCALE, 16'd1);
          write_reg(REG_REF, 16'd1024);
        end
        default: begin
          ref_pick = ($urandom_range(0, 3) == 0) ? CFG_W'($urandom_range(1024, 65535))
                                                  : CFG_W'($urandom_range(1024, 4095));
          write_reg(REG_SCALE, CFG_W'($urandom_range(1, 65535)));
          write_reg(REG_REF, ref_pick);
          if (p % 8 == 6) begin  // writes to unused indexes must change nothing
            write_reg(REG_SPARE_A, CFG_W'($urandom));
            write_reg(REG_SPARE_B, CFG_W'($urandom));
          end
        end
      endcase
      repeat (12) queue_batch();
      // leave a partial batch to carry across the next register change
      if (p % 2 == 1)
        repeat ($urandom_range(0, 9)) sample_feed_q.push_back(ADC_BITS'($urandom_range(0, 1023)));
      drain_and_settle();
    end

    $display("Run covered %0d samples and %0d readings over %0d register settings",
             samples_in, readings_checked, RANDOM_PHASES + 1);
    $display("Segments reached: %0d of %0d; out of range: %0d; saturated: %0d",
             $countones(seg_seen), SEG_COUNT, out_of_range_seen, saturated_seen);
    if (mismatch_count == 0 && temp_readings_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
